/* design/assert_macros.svh */
// Assertion shorthands for the run-length line map.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge out of reset
`define AST_HOLDS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("run-length map check failed");
// Expression must never be true at a clock edge out of reset
`define AST_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("run-length map forbidden condition seen");
`else
`define AST_HOLDS(lbl, clk, rstn, prop)
`define AST_NEVER(lbl, clk, rstn, expr)
`endif
`endif

/* design/rlm_pkg.sv */
package rlm_pkg;

    // Transaction opcodes
    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // Fixed payload widths of the channels
    localparam int LINE_NUMBER_W = 16;
    localparam int QUERY_W       = 16;
    localparam int LINE_OUT_W    = 16;

    // Control half of the lookup token walking the cell row
    typedef struct packed {
        logic valid;
        logic hit;
    } token_ctl_t;

    // Write strobes broadcast to the cell row
    typedef struct packed {
        logic line_en;
        logic run_en;
    } entry_wr_t;

endpackage

/* design/rlm_cmd_if.sv */
interface rlm_cmd_if;
    import rlm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [LINE_NUMBER_W-1:0] line_number;
    logic [QUERY_W-1:0]       query_index;

    modport source (output valid, output func, output line_number, output query_index,
                    input ready);
    modport sink   (input valid, input func, input line_number, input query_index,
                    output ready);
endinterface

/* design/rlm_rsp_if.sv */
interface rlm_rsp_if;
    import rlm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [LINE_OUT_W-1:0] line_out;
    logic                  found;
    logic                  dropped;
    logic                  run_saturated;

    modport source (output valid, output line_out, output found, output dropped,
                    output run_saturated, input ready);
    modport sink   (input valid, input line_out, input found, input dropped,
                    input run_saturated, output ready);
endinterface

/* design/rlm_cell.sv */
module rlm_cell #(
    parameter int INDEX     = 0,
    parameter int ENTRIES   = 256,
    parameter int LINE_BITS = 16,
    parameter int RUN_BITS  = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  rlm_pkg::entry_wr_t                     wr,
    input  logic [$clog2(ENTRIES)-1:0]             wr_idx,
    input  logic [LINE_BITS-1:0]                   wr_line,
    input  logic [RUN_BITS-1:0]                    wr_run,
    input  rlm_pkg::token_ctl_t                    tin_ctl,
    input  logic [rlm_pkg::QUERY_W-1:0]            tin_rem,
    input  logic [$clog2(ENTRIES+1)-1:0]           tin_left,
    input  logic [LINE_BITS-1:0]                   tin_line,
    output rlm_pkg::token_ctl_t                    tout_ctl,
    output logic [rlm_pkg::QUERY_W-1:0]            tout_rem,
    output logic [$clog2(ENTRIES+1)-1:0]           tout_left,
    output logic [LINE_BITS-1:0]                   tout_line
);
    import rlm_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (RUN_BITS > QUERY_W) ? RUN_BITS : QUERY_W;

    logic [LINE_BITS-1:0] line_reg;
    logic [RUN_BITS-1:0]  run_reg;
    logic                 sel;
    logic                 consider;
    logic                 take;
    logic [CMP_W-1:0]     rem_ext;
    logic [CMP_W-1:0]     run_ext;
    logic [CMP_W-1:0]     diff;
    token_ctl_t           ctl_reg;
    token_ctl_t           ctl_next;
    logic [QUERY_W-1:0]   rem_reg;
    logic [QUERY_W-1:0]   rem_next;
    logic [CNT_W-1:0]     left_reg;
    logic [CNT_W-1:0]     left_next;
    logic [LINE_BITS-1:0] tline_reg;
    logic [LINE_BITS-1:0] tline_next;

    // Store this cell's entry when the write index names it
    assign sel = (wr_idx == IDX_W'(INDEX));

    always_ff @(posedge clk)
    begin
        if (wr.line_en && sel)
        begin
            line_reg <= wr_line;
        end
        if (wr.run_en && sel)
        begin
            run_reg <= wr_run;
        end
    end

    // Test the token against this run, else subtract the run and pass on
    always_comb
    begin
        consider   = tin_ctl.valid && !tin_ctl.hit && (tin_left != '0);
        rem_ext    = CMP_W'(tin_rem);
        run_ext    = CMP_W'(run_reg);
        diff       = rem_ext - run_ext;
        take       = consider && (rem_ext < run_ext);
        ctl_next.valid = tin_ctl.valid;
        ctl_next.hit   = tin_ctl.hit || take;
        rem_next   = (consider && !take) ? QUERY_W'(diff) : tin_rem;
        left_next  = (tin_left != '0) ? tin_left - 1'b1 : tin_left;
        tline_next = take ? line_reg : tin_line;
    end

    // Hand the token to the neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        left_reg  <= left_next;
        tline_reg <= tline_next;
    end

    assign tout_ctl  = ctl_reg;
    assign tout_rem  = rem_reg;
    assign tout_left = left_reg;
    assign tout_line = tline_reg;

endmodule

/* design/rlm_chain.sv */
module rlm_chain #(
    parameter int ENTRIES   = 256,
    parameter int LINE_BITS = 16,
    parameter int RUN_BITS  = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  rlm_pkg::entry_wr_t                     wr,
    input  logic [$clog2(ENTRIES)-1:0]             wr_idx,
    input  logic [LINE_BITS-1:0]                   wr_line,
    input  logic [RUN_BITS-1:0]                    wr_run,
    input  rlm_pkg::token_ctl_t                    tin_ctl,
    input  logic [rlm_pkg::QUERY_W-1:0]            tin_rem,
    input  logic [$clog2(ENTRIES+1)-1:0]           tin_left,
    input  logic [LINE_BITS-1:0]                   tin_line,
    output rlm_pkg::token_ctl_t                    tout_ctl,
    output logic [LINE_BITS-1:0]                   tout_line
);
    import rlm_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);

    token_ctl_t           ctl_w  [0:ENTRIES];
    logic [QUERY_W-1:0]   rem_w  [0:ENTRIES];
    logic [CNT_W-1:0]     left_w [0:ENTRIES];
    logic [LINE_BITS-1:0] line_w [0:ENTRIES];

    // Feed the token into the first cell
    assign ctl_w[0]  = tin_ctl;
    assign rem_w[0]  = tin_rem;
    assign left_w[0] = tin_left;
    assign line_w[0] = tin_line;

    // One cell per table entry, token advances one cell per cycle
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        rlm_cell #(
            .INDEX     (i),
            .ENTRIES   (ENTRIES),
            .LINE_BITS (LINE_BITS),
            .RUN_BITS  (RUN_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr        (wr),
            .wr_idx    (wr_idx),
            .wr_line   (wr_line),
            .wr_run    (wr_run),
            .tin_ctl   (ctl_w[i]),
            .tin_rem   (rem_w[i]),
            .tin_left  (left_w[i]),
            .tin_line  (line_w[i]),
            .tout_ctl  (ctl_w[i+1]),
            .tout_rem  (rem_w[i+1]),
            .tout_left (left_w[i+1]),
            .tout_line (line_w[i+1])
        );
    end

    // Remaining position and entry count are spent at the end of the row
    logic unused_tail;
    assign unused_tail = ^{rem_w[ENTRIES], left_w[ENTRIES]};

    assign tout_ctl  = ctl_w[ENTRIES] & {1'b1, ~unused_tail | unused_tail};
    assign tout_line = line_w[ENTRIES];

endmodule

/* design/run_length_line_map.sv */
// Channel  Role    Payload
// -------  ------  ---------------------------------------------
// cmd      sink    func, line_number, query_index
// rsp      source  line_out, found, dropped, run_saturated
//
// Append: the result is registered in the pending slot, then in the rsp register;
//   the last-entry registers and the cell are written as the command is taken.
// Lookup: the query walks the row of ENTRIES cells, one per cycle, then the pending slot and rsp register.
// One transaction is in work at a time; cmd is taken again once its result
//   moves from the pending slot to the rsp register, even while rsp stalls.
// Reset empties the table at once; no clearing pass.
module run_length_line_map #(
    parameter int ENTRIES   = 256,
    parameter int LINE_BITS = 16,
    parameter int RUN_BITS  = 16
) (
    input logic clk,
    input logic rst_n,
    rlm_cmd_if.sink   cmd,
    rlm_rsp_if.source rsp
);
    import rlm_pkg::*;

`include "assert_macros.svh"

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

    // Table bookkeeping
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [LINE_BITS-1:0] last_line_reg;
    logic [LINE_BITS-1:0] last_line_next;
    logic [RUN_BITS-1:0]  last_run_reg;
    logic [RUN_BITS-1:0]  last_run_next;

    // Sequencing
    logic walk_busy_reg;
    logic walk_busy_next;
    logic pend_valid_reg;
    logic pend_valid_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;

    // Result payloads
    logic [LINE_OUT_W-1:0] pend_line_reg;
    logic                  pend_found_reg;
    logic                  pend_dropped_reg;
    logic                  pend_sat_reg;
    logic [LINE_OUT_W-1:0] rsp_line_reg;
    logic                  rsp_found_reg;
    logic                  rsp_dropped_reg;
    logic                  rsp_sat_reg;

    logic                 cmd_fire;
    logic                 is_append;
    logic                 is_lookup;
    logic [LINE_BITS-1:0] line_in;
    logic                 match;
    logic                 full;
    logic                 sat;
    logic                 drop;
    logic                 pend_move;
    entry_wr_t            wr;
    logic [IDX_W-1:0]     wr_idx;
    logic [RUN_BITS-1:0]  wr_run;
    token_ctl_t           tin_ctl;
    token_ctl_t           tout_ctl;
    logic [LINE_BITS-1:0] tout_line;

    // Accept one transaction at a time into an empty pending slot
    assign cmd.ready = !walk_busy_reg && !pend_valid_reg;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign is_append = cmd_fire && (cmd.func == FUNC_APPEND);
    assign is_lookup = cmd_fire && (cmd.func == FUNC_LOOKUP);

    // Decide the append against the last stored entry
    always_comb
    begin
        line_in    = LINE_BITS'(cmd.line_number);
        match      = (count_reg != '0) && (last_line_reg == line_in);
        full       = (count_reg == CNT_W'(ENTRIES));
        sat        = match && (last_run_reg == RUN_MAX);
        drop       = !match && full;
        wr.line_en = is_append && !match && !full;
        wr.run_en  = is_append && !sat && !drop;
        wr_idx     = match ? IDX_W'(count_reg - 1'b1) : IDX_W'(count_reg);
        wr_run     = match ? last_run_reg + 1'b1 : RUN_BITS'(1);

        count_next     = count_reg;
        last_line_next = last_line_reg;
        last_run_next  = last_run_reg;
        if (wr.line_en)
        begin
            count_next     = count_reg + 1'b1;
            last_line_next = line_in;
            last_run_next  = RUN_BITS'(1);
        end
        else if (wr.run_en)
        begin
            last_run_next  = wr_run;
        end
    end

    // Launch a lookup token with the count of stored entries
    assign tin_ctl.valid = is_lookup;
    assign tin_ctl.hit   = 1'b0;

    rlm_chain #(
        .ENTRIES   (ENTRIES),
        .LINE_BITS (LINE_BITS),
        .RUN_BITS  (RUN_BITS)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .wr_idx    (wr_idx),
        .wr_line   (line_in),
        .wr_run    (wr_run),
        .tin_ctl   (tin_ctl),
        .tin_rem   (cmd.query_index),
        .tin_left  (count_reg),
        .tin_line  ('0),
        .tout_ctl  (tout_ctl),
        .tout_line (tout_line)
    );

    // Advance results: pending slot, then rsp register
    always_comb
    begin
        pend_move       = pend_valid_reg && (!rsp_valid_reg || rsp.ready);
        walk_busy_next  = walk_busy_reg;
        pend_valid_next = pend_valid_reg;
        rsp_valid_next  = rsp_valid_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (pend_move)
        begin
            rsp_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
        if (is_lookup)
        begin
            walk_busy_next = 1'b1;
        end
        if (tout_ctl.valid)
        begin
            walk_busy_next  = 1'b0;
            pend_valid_next = 1'b1;
        end
        if (is_append)
        begin
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            walk_busy_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            walk_busy_reg  <= walk_busy_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Hold the last entry copy and the result payloads
    always_ff @(posedge clk)
    begin
        last_line_reg <= last_line_next;
        last_run_reg  <= last_run_next;
        if (tout_ctl.valid)
        begin
            pend_line_reg    <= tout_ctl.hit ? LINE_OUT_W'(tout_line) : '0;
            pend_found_reg   <= tout_ctl.hit;
            pend_dropped_reg <= 1'b0;
            pend_sat_reg     <= 1'b0;
        end
        else if (is_append)
        begin
            pend_line_reg    <= '0;
            pend_found_reg   <= 1'b0;
            pend_dropped_reg <= drop;
            pend_sat_reg     <= sat;
        end
        if (pend_move)
        begin
            rsp_line_reg    <= pend_line_reg;
            rsp_found_reg   <= pend_found_reg;
            rsp_dropped_reg <= pend_dropped_reg;
            rsp_sat_reg     <= pend_sat_reg;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.line_out      = rsp_line_reg;
    assign rsp.found         = rsp_found_reg;
    assign rsp.dropped       = rsp_dropped_reg;
    assign rsp.run_saturated = rsp_sat_reg;

    // Checks
    `AST_NEVER(a_count_bound, clk, rst_n, count_reg > CNT_W'(ENTRIES))
    `AST_HOLDS(a_token_owned, clk, rst_n, tout_ctl.valid |-> walk_busy_reg && !pend_valid_reg)
    `AST_HOLDS(a_pend_moves, clk, rst_n, pend_move |=> rsp_valid_reg && !pend_valid_reg)
    `AST_HOLDS(a_last_run_nonzero, clk, rst_n, (count_reg != '0) |-> (last_run_reg != '0))

endmodule

/* tb/sv/tb_run_length_line_map.sv */
`timescale 1ns / 1ps

module tb_run_length_line_map;
    import rlm_pkg::*;

    localparam int          ENTRIES      = 256;
    localparam int          LINE_BITS    = 16;
    localparam int          RUN_BITS     = 16;
    localparam int unsigned RUN_MAX      = 32'((64'd1 << RUN_BITS) - 64'd1);
    localparam int          RANDOM_ITEMS = 850;

    typedef struct packed {
        logic [LINE_OUT_W-1:0] line_out;
        logic                  found;
        logic                  dropped;
        logic                  run_saturated;
    } map_answer_t;

    typedef enum {READY_ALWAYS, READY_PATTERN, READY_COIN} ready_mode_t;

    // Shadow line table plus the queue of answers still owed by the block
    class line_map_predictor;
        logic [LINE_BITS-1:0] run_line [ENTRIES];
        int unsigned          run_len  [ENTRIES];
        int                   run_count;
        longint unsigned      byte_total;
        map_answer_t          awaited [$];
        int                   errors;
        int                   appends;
        int                   lookups;
        int                   hits;
        int                   drops;
        int                   saturations;

        function new();
            run_count   = 0;
            byte_total  = 0;
            errors      = 0;
            appends     = 0;
            lookups     = 0;
            hits        = 0;
            drops       = 0;
            saturations = 0;
        endfunction

        function logic [LINE_NUMBER_W-1:0] last_line();
            if (run_count == 0)
                return '0;
            return LINE_NUMBER_W'(run_line[run_count-1]);
        endfunction

        function int unsigned last_run();
            if (run_count == 0)
                return 0;
            return run_len[run_count-1];
        endfunction

        // Update the shadow table for an accepted command and queue its answer
        function void note_command(logic f, logic [LINE_NUMBER_W-1:0] ln,
                                   logic [QUERY_W-1:0] qi);
            map_answer_t          ans;
            logic [LINE_BITS-1:0] line;
            longint unsigned      start;
            ans   = '0;
            line  = LINE_BITS'(ln);
            start = 0;
            if (f == FUNC_APPEND)
            begin
                appends++;
                if (run_count > 0 && run_line[run_count-1] == line)
                begin
                    // same line as the last entry: extend its run or flag the ceiling
                    if (run_len[run_count-1] >= RUN_MAX)
                    begin
                        ans.run_saturated = 1'b1;
                        saturations++;
                    end
                    else
                    begin
                        run_len[run_count-1]++;
                        byte_total++;
                    end
                end
                else if (run_count >= ENTRIES)
                begin
                    ans.dropped = 1'b1;
                    drops++;
                end
                else
                begin
                    run_line[run_count] = line;
                    run_len[run_count]  = 1;
                    run_count++;
                    byte_total++;
                end
            end
            else
            begin
                lookups++;
                // walk the runs until the position falls inside one
                for (int i = 0; i < run_count; i++)
                begin
                    if (qi < start + run_len[i])
                    begin
                        ans.found    = 1'b1;
                        ans.line_out = LINE_OUT_W'(run_line[i]);
                        hits++;
                        break;
                    end
                    start += run_len[i];
                end
            end
            awaited.push_back(ans);
        endfunction

        // Compare one answer from the block against the oldest one owed
        function void check_answer(map_answer_t got);
            map_answer_t want;
            if (awaited.size() == 0)
            begin
                $error("answer with none owed: line_out %0h found %0b", got.line_out, got.found);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.line_out !== want.line_out)
            begin
                $error("line_out: expected %0h, got %0h", want.line_out, got.line_out);
                errors++;
            end
            if (got.found !== want.found)
            begin
                $error("found: expected %0b, got %0b", want.found, got.found);
                errors++;
            end
            if (got.dropped !== want.dropped)
            begin
                $error("dropped: expected %0b, got %0b", want.dropped, got.dropped);
                errors++;
            end
            if (got.run_saturated !== want.run_saturated)
            begin
                $error("run_saturated: expected %0b, got %0b",
                       want.run_saturated, got.run_saturated);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    rlm_cmd_if cmd ();
    rlm_rsp_if rsp ();

    line_map_predictor board = new();

    int burst_left = 0;
    bit steady     = 1'b0;

    run_length_line_map #(
        .ENTRIES   (ENTRIES),
        .LINE_BITS (LINE_BITS),
        .RUN_BITS  (RUN_BITS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Offer one command transaction; between bursts, unless steady, drop valid for a random gap
    task automatic push_item(input logic f, input logic [LINE_NUMBER_W-1:0] ln,
                             input logic [QUERY_W-1:0] qi);
        int gap;
        if (burst_left == 0 && !steady)
        begin
            cmd.valid <= 1'b0;
            gap = $urandom_range(1, 16);
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        cmd.valid       <= 1'b1;
        cmd.func        <= f;
        cmd.line_number <= ln;
        cmd.query_index <= qi;
        do
            @(posedge clk);
        while (!cmd.ready);
        board.note_command(f, ln, qi);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Hold the sender until every owed answer is back
    task automatic drain();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Receiver: stall in randomly chosen modes: always ready, a rotating pattern, or a coin toss
    initial
    begin : receiver
        ready_mode_t mode;
        int          mode_left;
        logic [7:0]  pattern;
        mode      = READY_ALWAYS;
        mode_left = 0;
        pattern   = 8'h01;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = ready_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(16, 96);
                pattern   = 8'($urandom_range(1, 255));
            end
            mode_left--;
            case (mode)
                READY_ALWAYS:
                    rsp.ready <= 1'b1;
                READY_PATTERN:
                begin
                    rsp.ready <= pattern[0];
                    pattern = {pattern[0], pattern[7:1]};
                end
                default:
                    rsp.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Check every response transaction as it is taken
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            board.check_answer('{line_out: rsp.line_out, found: rsp.found,
                                 dropped: rsp.dropped, run_saturated: rsp.run_saturated});
    end

    initial
    begin : stimulus
        int                         pick;
        int unsigned                span;
        logic [LINE_NUMBER_W-1:0]   ln;
        logic [QUERY_W-1:0]         qi;
        int unsigned                extra;

        rst_n           <= 1'b0;
        cmd.valid       <= 1'b0;
        cmd.func        <= FUNC_APPEND;
        cmd.line_number <= '0;
        cmd.query_index <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, edge line values, ignored fields, past-the-end lookups
        push_item(FUNC_LOOKUP, 16'hFFFF, 16'h0000);
        push_item(FUNC_LOOKUP, 16'h0000, 16'hFFFF);
        push_item(FUNC_APPEND, 16'h0000, 16'hFFFF);
        push_item(FUNC_APPEND, 16'h0000, 16'h0000);
        push_item(FUNC_APPEND, 16'hFFFF, 16'hFFFF);
        push_item(FUNC_APPEND, 16'hFFFF, 16'h5A5A);
        push_item(FUNC_APPEND, 16'h1234, 16'h0000);
        push_item(FUNC_APPEND, 16'h0000, 16'hA5A5);
        for (int p = 0; p <= 6; p++)
            push_item(FUNC_LOOKUP, 16'(p * 16'h2493), 16'(p));
        push_item(FUNC_LOOKUP, 16'hA5A5, 16'hFFFF);

        // Let the block go fully idle once before the random traffic
        cmd.valid  <= 1'b0;
        burst_left = 0;
        drain();

        // Random traffic: appends that often repeat the last line, mostly in-range lookups, some random commands
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                push_item(1'($urandom), 16'($urandom), 16'($urandom));
            else if (pick < 45)
            begin
                span = (board.byte_total > 65535) ? 65535 : int'(board.byte_total);
                if (span == 0 || $urandom_range(0, 7) == 0)
                    qi = 16'($urandom);
                else
                    qi = 16'($urandom_range(0, span));
                push_item(FUNC_LOOKUP, 16'($urandom), qi);
            end
            else
            begin
                if ($urandom_range(0, 9) < 4)
                    ln = board.last_line();
                else
                    ln = 16'($urandom);
                push_item(FUNC_APPEND, ln, 16'($urandom));
            end
        end

        // Fill the table, then push new lines that must be dropped
        while (board.run_count < ENTRIES)
        begin
            ln = board.last_line() ^ 16'($urandom_range(1, 65535));
            push_item(FUNC_APPEND, ln, 16'($urandom));
        end
        repeat (4)
        begin
            ln = board.last_line() ^ 16'($urandom_range(1, 65535));
            push_item(FUNC_APPEND, ln, 16'($urandom));
        end

        // Grow the last run of the full table back to back, without sender gaps
        steady = 1'b1;
        extra  = $urandom_range(16, 32);
        repeat (extra)
            push_item(FUNC_APPEND, board.last_line(), 16'($urandom));
        steady = 1'b0;

        // Lookups across the full table
        push_item(FUNC_LOOKUP, 16'($urandom), 16'hFFFF);
        push_item(FUNC_LOOKUP, 16'($urandom), 16'h0000);
        repeat (6)
            push_item(FUNC_LOOKUP, 16'($urandom), 16'($urandom));

        // Wait out the last answers, then allow for any stray ones
        cmd.valid <= 1'b0;
        drain();
        repeat (ENTRIES + 8) @(posedge clk);

        $display("Covered %0d appends (%0d dropped, %0d saturated) and %0d lookups (%0d hits);",
                 board.appends, board.drops, board.saturations, board.lookups, board.hits);
        $display("table reached %0d of %0d entries holding %0d bytes.",
                 board.run_count, ENTRIES, board.byte_total);
        if (board.errors == 0)
            $display("PASS run_length_line_map");
        else
            $display("FAIL run_length_line_map");
        $finish;
    end

    // Abort a run that hangs
    initial
    begin : watchdog
        #20_000_000;
        $display("FAIL run_length_line_map");
        $finish;
    end

endmodule
